// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers, clocked on clk and quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/pdhf_pkg.sv -----
package pdhf_pkg;

  localparam int CHAN_W       = 5;
  localparam int SAMPLE_W     = 10;
  localparam int LEVEL_W      = 7;
  localparam int LEVEL_SHIFT  = 3;
  localparam int THR_W        = 7;
  localparam int CHANNELS_DEF = 32;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

  // Per-channel state entry kept in the state RAM.
  typedef struct packed {
    logic               falling;
    logic [LEVEL_W-1:0] level;
  } pdhf_entry_t;

  localparam int ENTRY_W = $bits(pdhf_entry_t);

endpackage

// ----- hw/rtl/pdhf_ram.sv -----
module pdhf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/pot_direction_hysteresis_filter.sv -----
// Direction-aware hysteresis filter for multiplexed potentiometer samples.
// Input channel (in_valid/in_ready): in_channel, in_sample (10-bit reading).
// Result channel (out_valid/out_ready): out_report, out_channel, out_level,
// exactly one result word per input word, in input order.
// Config channel (cfg_valid/cfg_ready): cfg_data is the noise threshold;
// cfg_ready is always high. Write it only while the filter is idle.
// An accepted word is captured in the stage 1 registers, then moves to the
// output register; throughput is one word per cycle while not stalled.
// The per-channel state sits in a RAM with a registered read; a result
// written back in the same cycle that the next word reads the same channel
// is forwarded around the RAM.
// Reset: threshold returns to 1, every channel reads as level 0 and rising
// (per-entry valid bits are cleared, no clearing pass), pipeline empties.
// Stall: while out_ready is low the output register holds its word, the
// middle stage fills, and then in_ready drops until the output drains.
module pot_direction_hysteresis_filter #(
  parameter int CHANNELS = pdhf_pkg::CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pdhf_pkg::CHAN_W-1:0]  in_channel,
  input  logic [pdhf_pkg::SAMPLE_W-1:0] in_sample,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_report,
  output logic [pdhf_pkg::CHAN_W-1:0]  out_channel,
  output logic [pdhf_pkg::LEVEL_W-1:0] out_level,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pdhf_pkg::THR_W-1:0]   cfg_data
);

`include "assert_macros.svh"

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CMP_W = (IDX_W > pdhf_pkg::CHAN_W) ? IDX_W : pdhf_pkg::CHAN_W;
  localparam int LW    = pdhf_pkg::LEVEL_W;

  // configuration
  logic [pdhf_pkg::THR_W-1:0] thr_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= pdhf_pkg::THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_data;
    end
  end

  // input decode
  logic             in_accept;
  logic [CMP_W-1:0] in_chan_ext;
  logic [IDX_W-1:0] in_addr;
  logic             in_inrange;
  logic [LW-1:0]    in_level;

  assign in_accept   = in_valid && in_ready;
  assign in_chan_ext = CMP_W'(in_channel);
  assign in_addr     = in_chan_ext[IDX_W-1:0];
  assign in_inrange  = 32'(in_channel) < 32'(CHANNELS);
  assign in_level    = LW'(in_sample >> pdhf_pkg::LEVEL_SHIFT);

  // stage 1 registers
  logic                         s1_vld_r;
  logic [pdhf_pkg::CHAN_W-1:0]  s1_channel_r;
  logic [IDX_W-1:0]             s1_addr_r;
  logic [LW-1:0]                s1_level_r;
  logic                         s1_inrange_r;
  logic                         s1_entry_vld_r;
  logic                         s1_fwd_hit_r;
  pdhf_pkg::pdhf_entry_t        s1_fwd_data_r;
  logic                         s1_go;

  // state storage
  logic [CHANNELS-1:0]          valid_r;
  logic                         ram_we;
  pdhf_pkg::pdhf_entry_t        ram_wdata;
  logic [pdhf_pkg::ENTRY_W-1:0] ram_rdata;
  logic                         fwd_hit;

  pdhf_ram #(
    .WIDTH (pdhf_pkg::ENTRY_W),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr_r),
    .wdata (ram_wdata),
    .re    (in_accept),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  assign fwd_hit = ram_we && (s1_addr_r == in_addr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ram_we) begin
      valid_r[s1_addr_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_channel_r   <= in_channel;
      s1_addr_r      <= in_addr;
      s1_level_r     <= in_level;
      s1_inrange_r   <= in_inrange;
      s1_entry_vld_r <= in_inrange && valid_r[in_addr];
      s1_fwd_hit_r   <= fwd_hit;
      s1_fwd_data_r  <= ram_wdata;
    end
  end

  // decision
  pdhf_pkg::pdhf_entry_t prev;
  logic [LW:0]           lvl_plus_t;
  logic [LW:0]           prev_plus_t;
  logic                  move_fwd;
  logic                  reversal;
  logic                  rep;

  always_comb begin
    if (s1_fwd_hit_r) begin
      prev = s1_fwd_data_r;
    end else if (s1_entry_vld_r) begin
      prev = pdhf_pkg::pdhf_entry_t'(ram_rdata);
    end else begin
      prev = '0;
    end
    lvl_plus_t  = {1'b0, s1_level_r} + {1'b0, thr_r};
    prev_plus_t = {1'b0, prev.level} + {1'b0, thr_r};
    if (!prev.falling) begin
      move_fwd = s1_level_r > prev.level;
      reversal = lvl_plus_t < {1'b0, prev.level};
    end else begin
      move_fwd = s1_level_r < prev.level;
      reversal = {1'b0, s1_level_r} > prev_plus_t;
    end
    rep = s1_inrange_r && (move_fwd || reversal);
    ram_wdata.falling = prev.falling ^ (reversal && !move_fwd);
    ram_wdata.level   = s1_level_r;
  end

  assign ram_we = s1_go && rep;

  // output register
  logic                        out_valid_r;
  logic                        out_report_r;
  logic [pdhf_pkg::CHAN_W-1:0] out_channel_r;
  logic [LW-1:0]               out_level_r;

  assign s1_go    = s1_vld_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_vld_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_report_r  <= rep;
      out_channel_r <= s1_channel_r;
      out_level_r   <= s1_level_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_report  = out_report_r;
  assign out_channel = out_channel_r;
  assign out_level   = out_level_r;

  `ASSERT_IMP(a_no_report_out_of_range, out_valid_r && out_report_r,
    32'(out_channel_r) < 32'(CHANNELS), "report on channel beyond range")
  `ASSERT_NXT(a_fwd_captured, in_accept && fwd_hit, s1_fwd_hit_r,
    "write-back to the channel being read was not forwarded")
  `ASSERT_IMP(a_report_changes_level, s1_go && rep, s1_level_r != prev.level,
    "report with unchanged level")

endmodule
